// ===== hdl/cna_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types, widths and tables for the complex-number ALU: the microcode
// control word, datapath widths, the CORDIC arctangent table and saturation.
// ----------------------------------------------------------------------------
package cna_pkg;

  // Operand and result formats
  localparam int OperandW = 16;   // signed Q4.11
  localparam int ResultW  = 24;   // signed Q12.11
  localparam int OpW      = 3;

  // Datapath widths
  localparam int DataW  = 34;     // working registers X and Y
  localparam int AngleW = 28;     // angle accumulator, 2^-24 rad
  localparam int MulAW  = 32;
  localparam int MulBW  = 25;
  localparam int ProdW  = MulAW + MulBW;
  localparam int Guard  = 12;     // guard fraction bits for CORDIC

  // CORDIC table
  localparam int AtanDepth = 24;
  localparam int IterW     = 5;

  // Microcode address space
  localparam int PcW = 5;

  localparam logic signed [ResultW-1:0] Max24 = 24'sh7F_FFFF;
  localparam logic signed [ResultW-1:0] Min24 = -24'sh80_0000;
  localparam logic signed [DataW-1:0]   HalfPiQ11 = 34'sd3217;
  localparam logic signed [MulBW-1:0]   KinvQ24 = 25'sd10188014;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_CONJ = 3'd3,
    OP_MAG  = 3'd4,
    OP_DIR  = 3'd5,
    OP_ACC  = 3'd6,
    OP_NOP  = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    X_HOLD, X_SUM, X_DIFF, X_AR, X_ABS, X_CORDIC, X_PROD, X_PROD_SUB,
    X_ROUND, X_MAG, X_ANGLE, X_DIRZ, X_ACC
  } xsel_e;

  typedef enum logic [3:0] {
    Y_HOLD, Y_SUM, Y_DIFF, Y_NEG_AI, Y_ABS, Y_DIR, Y_CORDIC, Y_PROD,
    Y_PROD_ADD, Y_ROUND, Y_ZERO, Y_ACC
  } ysel_e;

  typedef enum logic [1:0] {Z_HOLD, Z_CLEAR, Z_CORDIC} zsel_e;

  typedef enum logic [2:0] {
    M_HOLD, M_AR_BR, M_AI_BI, M_AR_BI, M_AI_BR, M_X_KINV
  } msel_e;

  typedef enum logic [1:0] {A_HOLD, A_ADD, A_CLEAR} asel_e;

  typedef enum logic [1:0] {E_NONE, E_PLAIN, E_ZERO, E_ACC} esel_e;

  typedef enum logic [1:0] {C_NEVER, C_ITER_MORE, C_AR_ZERO, C_NOT_LAST} csel_e;

  typedef struct packed {
    xsel_e          x_sel;
    ysel_e          y_sel;
    zsel_e          z_sel;
    msel_e          mul_sel;
    asel_e          acc_sel;
    esel_e          emit_sel;
    csel_e          cond_sel;
    logic [PcW-1:0] target;
    logic           fin;
  } ctrl_t;

  typedef struct packed {
    logic ar_zero;
    logic last;
  } cond_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [AngleW-1:0] atan_q24(input logic [IterW-1:0] idx);
    logic signed [AngleW-1:0] v;
    case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ResultW-1:0] sat24(input logic signed [DataW-1:0] v);
    logic signed [ResultW-1:0] r;
    if (v > DataW'(Max24)) begin
      r = Max24;
    end else if (v < DataW'(Min24)) begin
      r = Min24;
    end else begin
      r = v[ResultW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/complex_number_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_number_alu
// Fixed-point complex ALU: add, subtract, multiply, conjugate, CORDIC
// magnitude and direction, and a saturating accumulator.
// ----------------------------------------------------------------------------
// One transaction at a time. After a transaction is taken the unit stalls its
// input until the microcode program for that operation finishes. Multiply runs
// four products through a single 32x25 multiplier. Magnitude and direction use
// the one shared CORDIC shift-add stage that runs one iteration per cycle;
// direction takes a shorter program when the real part is zero. A new
// transaction can be taken once the program finishes, while the previous
// result still waits in the output register. A program that reaches its
// result step while the output register is full and stalled holds there.
// Accumulate gives a result only on the transaction marked last_term_i.
// ----------------------------------------------------------------------------
module complex_number_alu #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [cna_pkg::OpW-1:0]               operation_i,
  input  wire logic signed [cna_pkg::OperandW-1:0]   a_real_i,
  input  wire logic signed [cna_pkg::OperandW-1:0]   a_imag_i,
  input  wire logic signed [cna_pkg::OperandW-1:0]   b_real_i,
  input  wire logic signed [cna_pkg::OperandW-1:0]   b_imag_i,
  input  wire logic                                  last_term_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [cna_pkg::ResultW-1:0]         res_real_o,
  output logic signed [cna_pkg::ResultW-1:0]         res_imag_o,
  output logic                                       overflow_o,
  output logic                                       zero_operand_o
);

  localparam int DW = cna_pkg::DataW;
  localparam int ZW = cna_pkg::AngleW;
  localparam int PW = cna_pkg::ProdW;
  localparam int RW = cna_pkg::ResultW;
  localparam int OW = cna_pkg::OperandW;

  localparam logic signed [DW-1:0] MulHalf  = 34'sd1024;
  localparam int                   MulShift = 11;
  localparam logic signed [ZW-1:0] AngHalf  = 28'sd4096;
  localparam int                   AngShift = 13;
  localparam logic signed [PW-1:0] MagHalf  = 57'sh8_0000_0000;
  localparam int                   MagShift = 36;

  // Handshake and sequencer
  logic                         in_accept;
  logic                         busy;
  logic                         step_en;
  logic                         out_take;
  cna_pkg::ctrl_t               ctrl;
  cna_pkg::cond_t               cond;
  logic [cna_pkg::IterW-1:0]    iter;

  // Operand registers
  logic signed [OW-1:0] ar_q, ai_q, br_q, bi_q;
  logic                 last_q;

  // Datapath registers
  logic signed [DW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic signed [RW-1:0]  sum_re_q, sum_re_d, sum_im_q, sum_im_d;
  logic                  sat_q, sat_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic signed [RW-1:0]  res_re_q, res_re_d, res_im_q, res_im_d;
  logic                  ovf_q, ovf_d, zf_q, zf_d;

  // Combinational helpers
  logic signed [DW-1:0]  ar_x, ai_x, br_x, bi_x;
  logic signed [DW-1:0]  ar_abs, ai_abs, ai_dir;
  logic signed [DW-1:0]  x_sh, y_sh;
  logic                  y_pos;
  logic signed [ZW-1:0]  atan_v;
  logic signed [cna_pkg::MulAW-1:0] mul_a;
  logic signed [cna_pkg::MulBW-1:0] mul_b;
  logic signed [PW-1:0]  mag_rnd;
  logic signed [ZW-1:0]  ang_rnd;
  logic signed [DW-1:0]  acc_re, acc_im;
  logic signed [RW-1:0]  acc_re_sat, acc_im_sat;
  logic                  acc_clip;
  logic                  emit;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = busy;
  assign out_take  = out_valid_q && !out_stall_i;
  assign emit      = (ctrl.emit_sel != cna_pkg::E_NONE);
  // Hold the program at a result step until the output register frees up
  assign step_en   = busy && !(emit && out_valid_q && out_stall_i);

  assign cond.ar_zero = (ar_q == '0);
  assign cond.last    = last_q;

  cna_sequencer #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .op_i     (operation_i),
    .step_en_i(step_en),
    .cond_i   (cond),
    .ctrl_o   (ctrl),
    .iter_o   (iter),
    .busy_o   (busy)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ar_q   <= a_real_i;
      ai_q   <= a_imag_i;
      br_q   <= b_real_i;
      bi_q   <= b_imag_i;
      last_q <= last_term_i;
    end
  end

  assign ar_x   = DW'(ar_q);
  assign ai_x   = DW'(ai_q);
  assign br_x   = DW'(br_q);
  assign bi_x   = DW'(bi_q);
  assign ar_abs = ar_q[OW-1] ? -ar_x : ar_x;
  assign ai_abs = ai_q[OW-1] ? -ai_x : ai_x;
  // Direction of a negated operand is the same quotient
  assign ai_dir = ar_q[OW-1] ? -ai_x : ai_x;

  assign x_sh   = x_q >>> iter;
  assign y_sh   = y_q >>> iter;
  assign y_pos  = !y_q[DW-1];
  assign atan_v = cna_pkg::atan_q24(iter);

  assign mag_rnd = prod_q + MagHalf;
  assign ang_rnd = z_q + AngHalf;

  assign acc_re     = DW'(sum_re_q) + ar_x;
  assign acc_im     = DW'(sum_im_q) + ai_x;
  assign acc_re_sat = cna_pkg::sat24(acc_re);
  assign acc_im_sat = cna_pkg::sat24(acc_im);
  assign acc_clip   = (DW'(acc_re_sat) != acc_re) || (DW'(acc_im_sat) != acc_im);

  // Multiplier operand select
  always_comb begin
    case (ctrl.mul_sel)
      cna_pkg::M_AR_BR: begin
        mul_a = cna_pkg::MulAW'(ar_q);
        mul_b = cna_pkg::MulBW'(br_q);
      end
      cna_pkg::M_AI_BI: begin
        mul_a = cna_pkg::MulAW'(ai_q);
        mul_b = cna_pkg::MulBW'(bi_q);
      end
      cna_pkg::M_AR_BI: begin
        mul_a = cna_pkg::MulAW'(ar_q);
        mul_b = cna_pkg::MulBW'(bi_q);
      end
      cna_pkg::M_AI_BR: begin
        mul_a = cna_pkg::MulAW'(ai_q);
        mul_b = cna_pkg::MulBW'(br_q);
      end
      cna_pkg::M_X_KINV: begin
        mul_a = x_q[cna_pkg::MulAW-1:0];
        mul_b = cna_pkg::KinvQ24;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_d = prod_q;
    if (ctrl.mul_sel != cna_pkg::M_HOLD) begin
      prod_d = mul_a * mul_b;
    end
  end

  always_comb begin
    case (ctrl.x_sel)
      cna_pkg::X_SUM:      x_d = ar_x + br_x;
      cna_pkg::X_DIFF:     x_d = ar_x - br_x;
      cna_pkg::X_AR:       x_d = ar_x;
      cna_pkg::X_ABS:      x_d = ar_abs <<< cna_pkg::Guard;
      cna_pkg::X_CORDIC:   x_d = y_pos ? x_q + y_sh : x_q - y_sh;
      cna_pkg::X_PROD:     x_d = DW'(prod_q);
      cna_pkg::X_PROD_SUB: x_d = x_q - DW'(prod_q);
      cna_pkg::X_ROUND:    x_d = (x_q + MulHalf) >>> MulShift;
      cna_pkg::X_MAG:      x_d = DW'(mag_rnd >>> MagShift);
      cna_pkg::X_ANGLE:    x_d = DW'(ang_rnd >>> AngShift);
      cna_pkg::X_DIRZ: begin
        if (ai_q == '0) begin
          x_d = '0;
        end else begin
          x_d = ai_q[OW-1] ? -cna_pkg::HalfPiQ11 : cna_pkg::HalfPiQ11;
        end
      end
      cna_pkg::X_ACC:      x_d = DW'(acc_re_sat);
      default:             x_d = x_q;
    endcase
  end

  always_comb begin
    case (ctrl.y_sel)
      cna_pkg::Y_SUM:      y_d = ai_x + bi_x;
      cna_pkg::Y_DIFF:     y_d = ai_x - bi_x;
      cna_pkg::Y_NEG_AI:   y_d = -ai_x;
      cna_pkg::Y_ABS:      y_d = ai_abs <<< cna_pkg::Guard;
      cna_pkg::Y_DIR:      y_d = ai_dir <<< cna_pkg::Guard;
      cna_pkg::Y_CORDIC:   y_d = y_pos ? y_q - x_sh : y_q + x_sh;
      cna_pkg::Y_PROD:     y_d = DW'(prod_q);
      cna_pkg::Y_PROD_ADD: y_d = y_q + DW'(prod_q);
      cna_pkg::Y_ROUND:    y_d = (y_q + MulHalf) >>> MulShift;
      cna_pkg::Y_ZERO:     y_d = '0;
      cna_pkg::Y_ACC:      y_d = DW'(acc_im_sat);
      default:             y_d = y_q;
    endcase
  end

  always_comb begin
    case (ctrl.z_sel)
      cna_pkg::Z_CLEAR:  z_d = '0;
      cna_pkg::Z_CORDIC: z_d = y_pos ? z_q + atan_v : z_q - atan_v;
      default:           z_d = z_q;
    endcase
  end

  always_comb begin
    sum_re_d = sum_re_q;
    sum_im_d = sum_im_q;
    sat_d    = sat_q;
    if (step_en) begin
      case (ctrl.acc_sel)
        cna_pkg::A_ADD: begin
          sum_re_d = acc_re_sat;
          sum_im_d = acc_im_sat;
          sat_d    = sat_q || acc_clip;
        end
        cna_pkg::A_CLEAR: begin
          sum_re_d = '0;
          sum_im_d = '0;
          sat_d    = 1'b0;
        end
        default: begin
          sat_d = sat_q;
        end
      endcase
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && !out_take;
    res_re_d    = res_re_q;
    res_im_d    = res_im_q;
    ovf_d       = ovf_q;
    zf_d        = zf_q;
    if (step_en && emit) begin
      out_valid_d = 1'b1;
      res_re_d    = cna_pkg::sat24(x_q);
      res_im_d    = cna_pkg::sat24(y_q);
      ovf_d       = (ctrl.emit_sel == cna_pkg::E_ACC) && sat_q;
      zf_d        = (ctrl.emit_sel == cna_pkg::E_ZERO) && (ai_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      prod_q <= prod_d;
    end
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    ovf_q    <= ovf_d;
    zf_q     <= zf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_re_q    <= '0;
      sum_im_q    <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_re_q    <= sum_re_d;
      sum_im_q    <= sum_im_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign res_real_o     = res_re_q;
  assign res_imag_o     = res_im_q;
  assign overflow_o     = ovf_q;
  assign zero_operand_o = zf_q;

endmodule
`default_nettype wire

// ===== hdl/cna_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cna_sequencer
// Microcode sequencer: program counter, CORDIC step counter and the control
// store that drives the datapath one control word per step.
// ----------------------------------------------------------------------------
module cna_sequencer #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cna_pkg::OpW-1:0]     op_i,
  input  wire logic                        step_en_i,
  input  wire cna_pkg::cond_t              cond_i,
  output cna_pkg::ctrl_t                   ctrl_o,
  output logic [cna_pkg::IterW-1:0]        iter_o,
  output logic                             busy_o
);

  localparam int StepsUsed = (CORDIC_STEPS > cna_pkg::AtanDepth) ?
                             cna_pkg::AtanDepth : CORDIC_STEPS;
  localparam logic [cna_pkg::IterW-1:0] IterLast = cna_pkg::IterW'(StepsUsed - 1);

  // Program entry points
  localparam logic [cna_pkg::PcW-1:0] PcAdd  = 5'd0;
  localparam logic [cna_pkg::PcW-1:0] PcSub  = 5'd2;
  localparam logic [cna_pkg::PcW-1:0] PcMul  = 5'd4;
  localparam logic [cna_pkg::PcW-1:0] PcConj = 5'd11;
  localparam logic [cna_pkg::PcW-1:0] PcMag  = 5'd13;
  localparam logic [cna_pkg::PcW-1:0] PcMagLoop = 5'd14;
  localparam logic [cna_pkg::PcW-1:0] PcDir  = 5'd18;
  localparam logic [cna_pkg::PcW-1:0] PcDirLoop = 5'd19;
  localparam logic [cna_pkg::PcW-1:0] PcDirZero = 5'd22;
  localparam logic [cna_pkg::PcW-1:0] PcAcc  = 5'd24;
  localparam logic [cna_pkg::PcW-1:0] PcDone = 5'd26;

  logic [cna_pkg::PcW-1:0]   pc_q, pc_d;
  logic                      busy_q, busy_d;
  logic [cna_pkg::IterW-1:0] iter_q, iter_d;
  logic [cna_pkg::PcW-1:0]   entry;
  logic                      taken;
  cna_pkg::ctrl_t            cw;

  // Entry decode
  always_comb begin
    case (cna_pkg::op_e'(op_i))
      cna_pkg::OP_ADD:  entry = PcAdd;
      cna_pkg::OP_SUB:  entry = PcSub;
      cna_pkg::OP_MUL:  entry = PcMul;
      cna_pkg::OP_CONJ: entry = PcConj;
      cna_pkg::OP_MAG:  entry = PcMag;
      cna_pkg::OP_DIR:  entry = PcDir;
      cna_pkg::OP_ACC:  entry = PcAcc;
      default:          entry = PcDone;
    endcase
  end

  // Control store
  always_comb begin
    cw = '{x_sel: cna_pkg::X_HOLD, y_sel: cna_pkg::Y_HOLD, z_sel: cna_pkg::Z_HOLD,
           mul_sel: cna_pkg::M_HOLD, acc_sel: cna_pkg::A_HOLD,
           emit_sel: cna_pkg::E_NONE, cond_sel: cna_pkg::C_NEVER,
           target: '0, fin: 1'b0};
    case (pc_q)
      // add
      5'd0: begin
        cw.x_sel = cna_pkg::X_SUM;
        cw.y_sel = cna_pkg::Y_SUM;
      end
      5'd1: begin
        cw.emit_sel = cna_pkg::E_PLAIN;
        cw.fin      = 1'b1;
      end
      // subtract
      5'd2: begin
        cw.x_sel = cna_pkg::X_DIFF;
        cw.y_sel = cna_pkg::Y_DIFF;
      end
      5'd3: begin
        cw.emit_sel = cna_pkg::E_PLAIN;
        cw.fin      = 1'b1;
      end
      // multiply: four products through one multiplier
      5'd4: begin
        cw.mul_sel = cna_pkg::M_AR_BR;
      end
      5'd5: begin
        cw.x_sel   = cna_pkg::X_PROD;
        cw.mul_sel = cna_pkg::M_AI_BI;
      end
      5'd6: begin
        cw.x_sel   = cna_pkg::X_PROD_SUB;
        cw.mul_sel = cna_pkg::M_AR_BI;
      end
      5'd7: begin
        cw.y_sel   = cna_pkg::Y_PROD;
        cw.mul_sel = cna_pkg::M_AI_BR;
      end
      5'd8: begin
        cw.y_sel = cna_pkg::Y_PROD_ADD;
      end
      5'd9: begin
        cw.x_sel = cna_pkg::X_ROUND;
        cw.y_sel = cna_pkg::Y_ROUND;
      end
      5'd10: begin
        cw.emit_sel = cna_pkg::E_PLAIN;
        cw.fin      = 1'b1;
      end
      // conjugate
      5'd11: begin
        cw.x_sel = cna_pkg::X_AR;
        cw.y_sel = cna_pkg::Y_NEG_AI;
      end
      5'd12: begin
        cw.emit_sel = cna_pkg::E_PLAIN;
        cw.fin      = 1'b1;
      end
      // magnitude
      5'd13: begin
        cw.x_sel = cna_pkg::X_ABS;
        cw.y_sel = cna_pkg::Y_ABS;
        cw.z_sel = cna_pkg::Z_CLEAR;
      end
      5'd14: begin
        cw.x_sel    = cna_pkg::X_CORDIC;
        cw.y_sel    = cna_pkg::Y_CORDIC;
        cw.z_sel    = cna_pkg::Z_CORDIC;
        cw.cond_sel = cna_pkg::C_ITER_MORE;
        cw.target   = PcMagLoop;
      end
      5'd15: begin
        cw.mul_sel = cna_pkg::M_X_KINV;
      end
      5'd16: begin
        cw.x_sel = cna_pkg::X_MAG;
        cw.y_sel = cna_pkg::Y_ZERO;
      end
      5'd17: begin
        cw.emit_sel = cna_pkg::E_PLAIN;
        cw.fin      = 1'b1;
      end
      // direction
      5'd18: begin
        cw.x_sel    = cna_pkg::X_ABS;
        cw.y_sel    = cna_pkg::Y_DIR;
        cw.z_sel    = cna_pkg::Z_CLEAR;
        cw.cond_sel = cna_pkg::C_AR_ZERO;
        cw.target   = PcDirZero;
      end
      5'd19: begin
        cw.x_sel    = cna_pkg::X_CORDIC;
        cw.y_sel    = cna_pkg::Y_CORDIC;
        cw.z_sel    = cna_pkg::Z_CORDIC;
        cw.cond_sel = cna_pkg::C_ITER_MORE;
        cw.target   = PcDirLoop;
      end
      5'd20: begin
        cw.x_sel = cna_pkg::X_ANGLE;
        cw.y_sel = cna_pkg::Y_ZERO;
      end
      5'd21: begin
        cw.emit_sel = cna_pkg::E_PLAIN;
        cw.fin      = 1'b1;
      end
      5'd22: begin
        cw.x_sel = cna_pkg::X_DIRZ;
        cw.y_sel = cna_pkg::Y_ZERO;
      end
      5'd23: begin
        cw.emit_sel = cna_pkg::E_ZERO;
        cw.fin      = 1'b1;
      end
      // accumulate
      5'd24: begin
        cw.x_sel    = cna_pkg::X_ACC;
        cw.y_sel    = cna_pkg::Y_ACC;
        cw.acc_sel  = cna_pkg::A_ADD;
        cw.cond_sel = cna_pkg::C_NOT_LAST;
        cw.target   = PcDone;
      end
      5'd25: begin
        cw.emit_sel = cna_pkg::E_ACC;
        cw.acc_sel  = cna_pkg::A_CLEAR;
        cw.fin      = 1'b1;
      end
      5'd26: begin
        cw.fin = 1'b1;
      end
      default: begin
        cw.fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (cw.cond_sel)
      cna_pkg::C_ITER_MORE: taken = (iter_q != IterLast);
      cna_pkg::C_AR_ZERO:   taken = cond_i.ar_zero;
      cna_pkg::C_NOT_LAST:  taken = !cond_i.last;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    iter_d = iter_q;
    if (start_i) begin
      pc_d   = entry;
      busy_d = 1'b1;
    end else if (step_en_i) begin
      pc_d = taken ? cw.target : pc_q + 1'b1;
      if (cw.fin) begin
        busy_d = 1'b0;
      end
      case (cw.z_sel)
        cna_pkg::Z_CLEAR:  iter_d = '0;
        cna_pkg::Z_CORDIC: iter_d = iter_q + 1'b1;
        default:           iter_d = iter_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  assign ctrl_o = cw;
  assign iter_o = iter_q;
  assign busy_o = busy_q;

endmodule
`default_nettype wire

// ===== hdl/cna_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cna_checker
// Port-level checks for the complex-number ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cna_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic [cna_pkg::OpW-1:0]             operation_i,
  input wire logic signed [cna_pkg::OperandW-1:0] a_real_i,
  input wire logic signed [cna_pkg::OperandW-1:0] a_imag_i,
  input wire logic signed [cna_pkg::OperandW-1:0] b_real_i,
  input wire logic signed [cna_pkg::OperandW-1:0] b_imag_i,
  input wire logic                                last_term_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic signed [cna_pkg::ResultW-1:0]  res_real_o,
  input wire logic signed [cna_pkg::ResultW-1:0]  res_imag_o,
  input wire logic                                overflow_o,
  input wire logic                                zero_operand_o
);

  // The input is stalled in the cycle after a transaction is taken
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transaction was taken");

  // Stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(res_real_o) && $stable(res_imag_o)
      && $stable(overflow_o) && $stable(zero_operand_o))
    else $error("stalled result changed");

  // Zero-operand direction gives a zero angle and no overflow
  a_zero_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_operand_o |->
      res_real_o == '0 && res_imag_o == '0 && !overflow_o)
    else $error("zero operand flag with nonzero result");

  // A new result only comes out of a transaction in progress
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no transaction in progress");

endmodule

bind complex_number_alu cna_checker u_cna_checker (.*);
`default_nettype wire

// ===== test/complex_number_alu_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_number_alu_tb
// Self-checking bench for the complex-number ALU. Streams directed corner
// operands and then random operations (accumulate runs, CORDIC magnitude and
// direction, multiply rounding, sum saturation) through the valid/stall
// channels. A scoreboard predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module complex_number_alu_tb;

  localparam int CordicSteps = 16;
  localparam int RandomItems = 650;

  typedef struct {
    cna_pkg::op_e                          op;
    logic signed [cna_pkg::OperandW-1:0]   ar;
    logic signed [cna_pkg::OperandW-1:0]   ai;
    logic signed [cna_pkg::OperandW-1:0]   br;
    logic signed [cna_pkg::OperandW-1:0]   bi;
    logic                                  last;
  } operand_set_t;

  typedef struct {
    logic [cna_pkg::ResultW-1:0] re;
    logic [cna_pkg::ResultW-1:0] im;
    logic                        ov;
    logic                        zf;
  } alu_result_t;

  // Predicts the unit's answers and matches them against what comes out.
  class cna_scoreboard;
    alu_result_t awaited[$];
    longint      sum_re;
    longint      sum_im;
    bit          sum_clipped;
    longint      atan_tab[24];
    int          steps;
    int          errors;

    function new(int n_steps);
      atan_tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                   131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
      steps       = (n_steps > 24) ? 24 : n_steps;
      sum_re      = 0;
      sum_im      = 0;
      sum_clipped = 0;
      errors      = 0;
    endfunction

    function longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function void push_result(longint re, longint im, bit ov, bit zf);
      alu_result_t r;
      r.re = 24'(clamp24(re));
      r.im = 24'(clamp24(im));
      r.ov = ov;
      r.zf = zf;
      awaited.push_back(r);
    endfunction

    // Rotate toward y = 0, collecting the angle in 2^-24 rad.
    function void vector_run(longint x0, longint y0, output longint xo, output longint zo);
      longint x, y, z, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      for (int i = 0; i < steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += atan_tab[i];
        end else begin
          x -= dx;
          y += dy;
          z -= atan_tab[i];
        end
      end
      xo = x;
      zo = z;
    endfunction

    function void log_operands(operand_set_t s);
      longint ar, ai, br, bi, x, z, re, im;
      ar = s.ar;
      ai = s.ai;
      br = s.br;
      bi = s.bi;
      case (s.op)
        cna_pkg::OP_ADD:  push_result(ar + br, ai + bi, 0, 0);
        cna_pkg::OP_SUB:  push_result(ar - br, ai - bi, 0, 0);
        cna_pkg::OP_MUL: begin
          re = (ar * br - ai * bi + 1024) >>> 11;
          im = (ar * bi + ai * br + 1024) >>> 11;
          push_result(re, im, 0, 0);
        end
        cna_pkg::OP_CONJ: push_result(ar, -ai, 0, 0);
        cna_pkg::OP_MAG: begin
          vector_run((ar < 0 ? -ar : ar) * 4096, (ai < 0 ? -ai : ai) * 4096, x, z);
          if (x > (longint'(1) << 37)) begin
            push_result(64'sd8388607, 0, 0, 0);
          end else begin
            re = (x * 10188014 + (longint'(1) << 35)) >>> 36;
            push_result(re, 0, 0, 0);
          end
        end
        cna_pkg::OP_DIR: begin
          if (ar == 0) begin
            if (ai == 0) push_result(0, 0, 0, 1);
            else push_result(ai > 0 ? 3217 : -3217, 0, 0, 0);
          end else begin
            // negate into the right half plane; the quotient stays the same
            if (ar < 0) begin
              ar = -ar;
              ai = -ai;
            end
            vector_run(ar * 4096, ai * 4096, x, z);
            push_result((z + 4096) >>> 13, 0, 0, 0);
          end
        end
        cna_pkg::OP_ACC: begin
          re = sum_re + ar;
          im = sum_im + ai;
          if (re != clamp24(re) || im != clamp24(im)) sum_clipped = 1;
          sum_re = clamp24(re);
          sum_im = clamp24(im);
          if (s.last) begin
            push_result(sum_re, sum_im, sum_clipped, 0);
            sum_re      = 0;
            sum_im      = 0;
            sum_clipped = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_result(logic [cna_pkg::ResultW-1:0] re,
                                 logic [cna_pkg::ResultW-1:0] im,
                                 logic ov, logic zf);
      alu_result_t e;
      if (awaited.size() == 0) begin
        $error("result with none awaited: res_real %h res_imag %h", re, im);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (re !== e.re) begin
        $error("res_real: expected %h, actual %h", e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $error("res_imag: expected %h, actual %h", e.im, im);
        errors++;
      end
      if (ov !== e.ov) begin
        $error("overflow: expected %b, actual %b", e.ov, ov);
        errors++;
      end
      if (zf !== e.zf) begin
        $error("zero_operand: expected %b, actual %b", e.zf, zf);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [cna_pkg::OpW-1:0] operation = '0;
  logic signed [cna_pkg::OperandW-1:0] a_real = '0;
  logic signed [cna_pkg::OperandW-1:0] a_imag = '0;
  logic signed [cna_pkg::OperandW-1:0] b_real = '0;
  logic signed [cna_pkg::OperandW-1:0] b_imag = '0;
  logic last_term = 1'b0;

  wire logic                                in_stall;
  wire logic                                out_valid;
  wire logic signed [cna_pkg::ResultW-1:0]  res_real;
  wire logic signed [cna_pkg::ResultW-1:0]  res_imag;
  wire logic                                overflow;
  wire logic                                zero_operand;

  bit quiet;
  bit hold_req;
  bit hold_done;

  cna_scoreboard book;
  operand_set_t  stim_q[$];
  int            directed_n;

  complex_number_alu #(
    .CORDIC_STEPS(CordicSteps)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .a_real_i      (a_real),
    .a_imag_i      (a_imag),
    .b_real_i      (b_real),
    .b_imag_i      (b_imag),
    .last_term_i   (last_term),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .res_real_o    (res_real),
    .res_imag_o    (res_imag),
    .overflow_o    (overflow),
    .zero_operand_o(zero_operand)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Record both channels' transactions on the edge that moves them.
  always @(posedge clk_i) begin
    operand_set_t s;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        s.op   = cna_pkg::op_e'(operation);
        s.ar   = a_real;
        s.ai   = a_imag;
        s.br   = b_real;
        s.bi   = b_imag;
        s.last = last_term;
        book.log_operands(s);
      end
      if (out_valid && !out_stall) begin
        book.compare_result(res_real, res_imag, overflow, zero_operand);
      end
    end
  end

  task automatic add_item(cna_pkg::op_e op, int ar, int ai, int br, int bi, bit last);
    operand_set_t s;
    s.op   = op;
    s.ar   = cna_pkg::OperandW'(ar);
    s.ai   = cna_pkg::OperandW'(ai);
    s.br   = cna_pkg::OperandW'(br);
    s.bi   = cna_pkg::OperandW'(bi);
    s.last = last;
    stim_q.push_back(s);
  endtask

  function automatic logic signed [cna_pkg::OperandW-1:0] rand_operand();
    int corners[5] = '{-32768, 32767, 0, 1, -1};
    case ($urandom_range(0, 7))
      0:       return cna_pkg::OperandW'(corners[$urandom_range(0, 4)]);
      1, 2:    return cna_pkg::OperandW'(int'($urandom_range(0, 512)) - 256);
      default: return cna_pkg::OperandW'($urandom());
    endcase
  endfunction

  task automatic build_stimulus();
    operand_set_t s;
    int len, sr, si, stop;
    bit sat_done;
    add_item(cna_pkg::OP_ADD, 32767, 32767, 32767, 32767, 0);
    add_item(cna_pkg::OP_ADD, -32768, -32768, -32768, -32768, 1);
    add_item(cna_pkg::OP_SUB, -32768, 32767, 32767, -32768, 0);
    add_item(cna_pkg::OP_SUB, 32767, -32768, -32768, 32767, 0);
    add_item(cna_pkg::OP_MUL, -32768, -32768, -32768, -32768, 0);
    add_item(cna_pkg::OP_MUL, 32767, -32768, -32768, 32767, 0);
    add_item(cna_pkg::OP_MUL, 1, 0, 1024, 0, 0);
    add_item(cna_pkg::OP_MUL, -1, 1, 1024, -1023, 0);
    add_item(cna_pkg::OP_CONJ, -32768, -32768, 0, 0, 0);
    add_item(cna_pkg::OP_CONJ, 32767, 32767, 5, 5, 0);
    add_item(cna_pkg::OP_MAG, -32768, -32768, 0, 0, 0);
    add_item(cna_pkg::OP_MAG, 0, 0, 0, 0, 0);
    add_item(cna_pkg::OP_MAG, 32767, 0, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, 0, 0, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, 0, 12, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, 0, -32768, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, -2048, 2048, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, -32768, -32768, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, 32767, 32767, 0, 0, 0);
    add_item(cna_pkg::OP_DIR, 100, 0, 0, 0, 0);
    add_item(cna_pkg::OP_ACC, 32767, -32768, 0, 0, 0);
    add_item(cna_pkg::OP_ACC, 32767, -32768, 7, 7, 1);
    add_item(cna_pkg::OP_NOP, 123, 456, 789, 1011, 1);
    add_item(cna_pkg::OP_ACC, -5, 9, 0, 0, 1);
    directed_n = stim_q.size();

    sat_done = 0;
    stop = directed_n + RandomItems;
    while (stim_q.size() < stop) begin
      if (!sat_done && stim_q.size() > directed_n + 150) begin
        // long run of large terms that clips both parts of the sum
        sat_done = 1;
        sr = $urandom_range(0, 1) ? 1 : -1;
        si = $urandom_range(0, 1) ? 1 : -1;
        for (int j = 0; j < 300; j++) begin
          add_item(cna_pkg::OP_ACC, sr * int'($urandom_range(31000, 32767)),
                   si * int'($urandom_range(31000, 32767)),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), j == 299);
        end
      end else begin
        case ($urandom_range(0, 15))
          0, 1: begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
              s.op   = cna_pkg::OP_ACC;
              s.ar   = rand_operand();
              s.ai   = rand_operand();
              s.br   = rand_operand();
              s.bi   = rand_operand();
              s.last = (j == len - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
              stim_q.push_back(s);
            end
          end
          2: begin
            s.op   = cna_pkg::OP_NOP;
            s.ar   = rand_operand();
            s.ai   = rand_operand();
            s.br   = rand_operand();
            s.bi   = rand_operand();
            s.last = $urandom_range(0, 1);
            stim_q.push_back(s);
          end
          default: begin
            s.op   = cna_pkg::op_e'($urandom_range(0, 5));
            s.ar   = rand_operand();
            s.ai   = rand_operand();
            s.br   = rand_operand();
            s.bi   = rand_operand();
            s.last = $urandom_range(0, 1);
            if (s.op == cna_pkg::OP_DIR && $urandom_range(0, 5) == 0) s.ar = '0;
            stim_q.push_back(s);
          end
        endcase
      end
    end
  endtask

  task automatic drive_item(operand_set_t s);
    operation <= s.op;
    a_real    <= s.ar;
    a_imag    <= s.ai;
    b_real    <= s.br;
    b_imag    <= s.bi;
    last_term <= s.last;
    in_valid  <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (book.outstanding() != 0);
  endtask

  // Receiver: random stall bursts, one long hold-off, then free running.
  initial begin : receiver
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_done = 1;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin : sender
    int hold_at, pause_at, quiet_from;
    book = new(CordicSteps);
    build_stimulus();
    hold_at    = directed_n + 60;
    pause_at   = directed_n + 420;
    quiet_from = stim_q.size() - 80;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < stim_q.size(); k++) begin
      if (k >= quiet_from) quiet = 1;
      if (k == directed_n || k == pause_at) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0) begin
        // idle with junk on the payload
        in_valid <= 1'b0;
        a_real   <= rand_operand();
        b_imag   <= rand_operand();
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      if (k == hold_at) hold_req = 1;
      drive_item(stim_q[k]);
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (book.errors == 0 && book.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
